/* rtl/sal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg: shared types and codes of the shift array list
// Word type, request action codes, result status codes and the cell control
// group that the list controller hands to every storage cell.
// ----------------------------------------------------------------------------
package sal_pkg;

    typedef logic signed [31:0] t_word;
    typedef logic [2:0]         t_action;
    typedef logic [1:0]         t_status;
    typedef logic [6:0]         t_count;
    typedef logic [5:0]         t_index;

    localparam t_action ACT_PUSH_END  = 3'd0;
    localparam t_action ACT_POP_END   = 3'd1;
    localparam t_action ACT_REM_FRONT = 3'd2;
    localparam t_action ACT_INS_FRONT = 3'd3;
    localparam t_action ACT_INS_AT    = 3'd4;
    localparam t_action ACT_REM_AT    = 3'd5;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_BADIDX = 2'd3;

    // Returned in place of a word when a removal finds the list empty.
    localparam t_word EMPTY_WORD = -32'sd9999;

    // Per-cycle command to the cell row.
    typedef struct packed {
        logic ins;  // open a hole at the position and store the new word
        logic rem;  // close the gap at the position
    } t_cell_ctl;

endpackage
`default_nettype wire

/* rtl/sal_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sal_if: request and response channels of the shift array list
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sal_req_if;
    import sal_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_word   value;
    t_index  index;

    modport source (output valid, output action, output value, output index, input ready);
    modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface sal_rsp_if;
    import sal_pkg::*;

    logic    valid;
    logic    ready;
    t_word   value_out;
    t_status status;
    t_count  count;

    modport source (output valid, output value_out, output status, output count, input ready);
    modport sink   (input valid, input value_out, input status, input count, output ready);
endinterface
`default_nettype wire

/* rtl/sal_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sal_cell: one storage cell of the list
// Holds one word and takes the word of a neighbour, the new word or its own
// on each insert or removal, according to its place against the position.
// ----------------------------------------------------------------------------
module sal_cell #(
    parameter int PW  = 6,
    parameter int IDX = 0
) (
    input  wire                      i_clk,
    input  wire sal_pkg::t_cell_ctl  i_ctl,
    input  wire [PW-1:0]             i_pos,
    input  wire sal_pkg::t_word      i_new,
    input  wire sal_pkg::t_word      i_below,
    input  wire sal_pkg::t_word      i_above,
    output sal_pkg::t_word           o_word
);
    import sal_pkg::*;

    localparam logic [PW-1:0] MY_POS = PW'(IDX);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (MY_POS > i_pos) begin
                n_word = i_below;
            end else if (MY_POS == i_pos) begin
                n_word = i_new;
            end
        end else if (i_ctl.rem) begin
            if (MY_POS >= i_pos) begin
                n_word = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

/* rtl/shift_array_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shift_array_list: ordered list of signed words with insert/remove at index
// A row of DEPTH cells holds the list packed from position 0 upwards.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on i_req (action, value, index) and each one produces
//   exactly one response on o_rsp (value_out, status, count). Both channels
//   are valid/ready; a transfer happens on a rising edge with both high.
//   Actions: push at end, pop from end, remove front, insert front, insert
//   at index, remove at index. On an insert every cell above the position
//   takes the word of the cell below it, and on a removal every cell at or
//   above the position takes the word of the cell above, all together.
//   The response is registered: the output register takes it on the edge
//   that transfers the request. Throughput is one request per cycle while
//   the receiver keeps up, as the whole cell row shifts at once.
//   A full list reports full, a removal from an empty list reports empty
//   with value -9999, an index past the end reports bad index; none of
//   these touch the list. Unused action codes report ok with no change.
//   Reset clears the entry count and the output valid flag; cell contents
//   are not cleared, since only entries below the count are ever read.
//   When the receiver stalls, the response is held and i_req.ready stays
//   low until it is taken; a new request is accepted in the cycle that
//   the waiting response is transferred.
// ----------------------------------------------------------------------------
module shift_array_list #(
    parameter int DEPTH = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sal_req_if.sink    i_req,
    sal_rsp_if.source  o_rsp
);
    import sal_pkg::*;

    // Count width holds DEPTH itself; position width indexes the cells.
    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    // Compare width wide enough for both the count and the request index.
    localparam int CW = (FW > 6) ? FW : 6;

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;

    logic    r_out_valid;
    t_word   r_value_out;
    t_status r_status;
    t_count  r_count;

    logic      accept;
    t_cell_ctl dec_ctl;
    t_cell_ctl cell_ctl;
    logic [PW-1:0] pos;
    t_status   dec_status;
    t_word     dec_value;
    logic      full;
    logic      empty;
    logic [CW-1:0] idx_c;
    logic [CW-1:0] fill_c;

    t_word w_word  [DEPTH];
    t_word w_below [DEPTH];
    t_word w_above [DEPTH];

    // The output register frees up in the cycle its response is taken.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full   = (r_fill == FW'(DEPTH));
    assign empty  = (r_fill == '0);
    assign idx_c  = CW'(i_req.index);
    assign fill_c = CW'(r_fill);

    // Request decode: the checks run in the order empty/full, then index.
    always_comb begin
        dec_ctl    = '0;
        pos        = '0;
        dec_status = ST_OK;
        dec_value  = '0;
        n_fill     = r_fill;
        unique case (i_req.action)
            ACT_PUSH_END, ACT_INS_FRONT, ACT_INS_AT: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else if (i_req.action == ACT_INS_AT && idx_c > fill_c) begin
                    dec_status = ST_BADIDX;
                end else begin
                    dec_ctl.ins = 1'b1;
                    n_fill      = r_fill + FW'(1);
                    if (i_req.action == ACT_PUSH_END) begin
                        pos = PW'(r_fill);
                    end else if (i_req.action == ACT_INS_AT) begin
                        pos = PW'(i_req.index);
                    end
                end
            end
            ACT_POP_END, ACT_REM_FRONT, ACT_REM_AT: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                    dec_value  = EMPTY_WORD;
                end else if (i_req.action == ACT_REM_AT && idx_c >= fill_c) begin
                    dec_status = ST_BADIDX;
                end else begin
                    dec_ctl.rem = 1'b1;
                    n_fill      = r_fill - FW'(1);
                    if (i_req.action == ACT_POP_END) begin
                        pos = PW'(r_fill - FW'(1));
                    end else if (i_req.action == ACT_REM_AT) begin
                        pos = PW'(i_req.index);
                    end
                    dec_value = w_word[pos];
                end
            end
            default: begin
                // Unused action codes leave the list as it is.
            end
        endcase
    end

    // The cell row only moves on a transferred request.
    assign cell_ctl.ins = dec_ctl.ins && accept;
    assign cell_ctl.rem = dec_ctl.rem && accept;

    // Neighbour wiring; the end cells see a zero word past the row.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_below[g] = '0;
        end else begin : g_mid_lo
            assign w_below[g] = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_above[g] = '0;
        end else begin : g_mid_hi
            assign w_above[g] = w_word[g+1];
        end

        sal_cell #(
            .PW  (PW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_pos   (pos),
            .i_new   (i_req.value),
            .i_below (w_below[g]),
            .i_above (w_above[g]),
            .o_word  (w_word[g])
        );
    end

    // Entry count and output valid are the only state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload; the count is reported in seven bits.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_out <= dec_value;
            r_status    <= dec_status;
            r_count     <= t_count'(n_fill);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.value_out = r_value_out;
    assign o_rsp.status    = r_status;
    assign o_rsp.count     = r_count;

    // The count can never pass the capacity of the row.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("entry count beyond capacity");

    // A served insert grows the list by exactly one entry.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.ins |=> r_fill == $past(r_fill) + FW'(1))
        else $error("insert did not grow the list by one");

    // A served removal shrinks the list by exactly one entry.
    a_rem_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.rem |=> r_fill == $past(r_fill) - FW'(1))
        else $error("removal did not shrink the list by one");

    // An empty report always carries the empty marker word.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |-> o_rsp.value_out == EMPTY_WORD)
        else $error("empty status without the empty marker word");

endmodule
`default_nettype wire
